// ===== rtl/bmu_pkg.sv =====
// Shared definitions for the 64-bit bit-manipulation unit.
// Holds operand widths, operation codes and the lane masks used by the count logic.
// No dependencies.
`default_nettype none

package bmu_pkg;

   localparam int unsigned DATA_W  = 64;
   localparam int unsigned OP_W    = 5;
   localparam int unsigned SHAMT_W = 6;
   localparam int unsigned CNT_W   = 7;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [DATA_W-1:0] word_type;

   localparam op_type OP_AND    = 5'd0;
   localparam op_type OP_OR     = 5'd1;
   localparam op_type OP_XOR    = 5'd2;
   localparam op_type OP_NOT    = 5'd3;
   localparam op_type OP_SHL    = 5'd4;
   localparam op_type OP_SAR    = 5'd5;
   localparam op_type OP_SHR    = 5'd6;
   localparam op_type OP_ROTL   = 5'd7;
   localparam op_type OP_ROTR   = 5'd8;
   localparam op_type OP_POPCNT = 5'd9;
   localparam op_type OP_CLZ    = 5'd10;
   localparam op_type OP_CTZ    = 5'd11;
   localparam op_type OP_BITREV = 5'd12;
   localparam op_type OP_BSWAP  = 5'd13;
   localparam op_type OP_GET    = 5'd14;
   localparam op_type OP_SET    = 5'd15;
   localparam op_type OP_CLEAR  = 5'd16;
   localparam op_type OP_TOGGLE = 5'd17;

   localparam word_type MASK_M1  = 64'h5555_5555_5555_5555;
   localparam word_type MASK_M2  = 64'h3333_3333_3333_3333;
   localparam word_type MASK_M4  = 64'h0F0F_0F0F_0F0F_0F0F;
   localparam word_type MASK_M8  = 64'h00FF_00FF_00FF_00FF;
   localparam word_type MASK_M16 = 64'h0000_FFFF_0000_FFFF;

   // SWAR population count, log-depth adder tree
   function automatic logic [CNT_W-1:0] ones_count(input word_type x);
      word_type t;
      t = x - ((x >> 1) & MASK_M1);
      t = (t & MASK_M2) + ((t >> 2) & MASK_M2);
      t = (t + (t >> 4)) & MASK_M4;
      t = t + (t >> 8);
      t = t + (t >> 16);
      t = t + (t >> 32);
      return t[CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bmu_alu.sv =====
// Combinational datapath of the bit-manipulation unit: logic, shifts, rotates,
// counts, reversal and single-bit operations. Depends on bmu_pkg.
`default_nettype none

module bmu_alu (
   input  bmu_pkg::op_type   op,
   input  bmu_pkg::word_type a,
   input  bmu_pkg::word_type b,
   output bmu_pkg::word_type result
);
   import bmu_pkg::*;

   logic                 in_range;
   logic [SHAMT_W-1:0]   shamt;
   logic [SHAMT_W:0]     rot_back;
   word_type             one_hot;
   word_type             fill;
   word_type             rev_a;
   word_type             cnt_src;
   word_type             low_run;
   logic [CNT_W-1:0]     cnt;

   assign in_range = (b[DATA_W-1:SHAMT_W] == '0);
   assign shamt    = b[SHAMT_W-1:0];
   assign rot_back = (SHAMT_W+1)'(DATA_W) - {1'b0, shamt};
   assign one_hot  = in_range ? (word_type'(1) << shamt) : '0;
   assign fill     = {DATA_W{a[DATA_W-1]}};
   assign rev_a    = {<<{a}};

   // trailing zeros = ones below the lowest set bit; clz works on the reversed word
   assign cnt_src = (op == OP_CLZ) ? rev_a : a;
   assign low_run = (cnt_src & (~cnt_src + word_type'(1))) - word_type'(1);
   assign cnt     = ones_count((op == OP_POPCNT) ? a : low_run);

   always_comb begin
      case (op)
         OP_AND:    result = a & b;
         OP_OR:     result = a | b;
         OP_XOR:    result = a ^ b;
         OP_NOT:    result = ~a;
         OP_SHL:    result = in_range ? (a << shamt) : '0;
         OP_SAR: begin
            if (b[DATA_W-1]) begin
               result = a;
            end else if (!in_range) begin
               result = fill;
            end else begin
               result = word_type'($signed(a) >>> shamt);
            end
         end
         OP_SHR:    result = in_range ? (a >> shamt) : '0;
         OP_ROTL:   result = (a << shamt) | (a >> rot_back);
         OP_ROTR:   result = (a >> shamt) | (a << rot_back);
         OP_POPCNT, OP_CLZ, OP_CTZ:
                    result = word_type'(cnt);
         OP_BITREV: result = rev_a;
         OP_BSWAP:  result = {<<8{a}};
         OP_GET:    result = in_range ? word_type'(a[shamt]) : '0;
         OP_SET:    result = a | one_hot;
         OP_CLEAR:  result = a & ~one_hot;
         OP_TOGGLE: result = a ^ one_hot;
         default:   result = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/bit_manipulation_unit_64.sv =====
// 64-bit bit-manipulation unit, top level. Depends on bmu_pkg and bmu_alu.
// Path from the start transfer to the rsp_valid strobe: input register, one pass
// through bmu_alu, result register.
// Throughput: one operation per cycle; busy stays low, results are never held off.
// Reset: synchronous, active high; clears the valid pipeline only, no result strobe follows.
`default_nettype none

module bit_manipulation_unit_64 (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  bmu_pkg::op_type          req_operation,
   input  logic signed [63:0]       req_operand_a,
   input  logic signed [63:0]       req_operand_b,
   output logic                     rsp_valid,
   output logic signed [63:0]       rsp_result
);
   import bmu_pkg::*;

   logic     req_valid_ff, req_valid_in;
   op_type   op_ff;
   word_type a_ff;
   word_type b_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   word_type result_ff;
   word_type alu_result;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;
   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         op_ff <= req_operation;
         a_ff  <= word_type'(req_operand_a);
         b_ff  <= word_type'(req_operand_b);
      end
      if (rsp_valid_in) begin
         result_ff <= alu_result;
      end
   end

   bmu_alu u_alu (
      .op     (op_ff),
      .a      (a_ff),
      .b      (b_ff),
      .result (alu_result)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = $signed(result_ff);

endmodule

`default_nettype wire
